@@ src/assert_macros.svh @@
// assertion macros shared by the block layout offset calculator rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is asserted
`define BLO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds across reset
`define BLO_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/blo_pkg.sv @@
// types, codes and constants of the block layout offset calculator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package blo_pkg;

  localparam int unsigned OFF_W           = 60;
  localparam int unsigned LOC_W           = 64;
  localparam int unsigned AMT_W           = 32;
  localparam int unsigned IDX_W           = 4;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned CFG_AW          = 3;
  localparam int unsigned CFG_DW          = 32;
  localparam int unsigned OUT_DW          = 128;
  localparam int unsigned IN_UW           = 4;

  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  // register indexes, decoded from paddr bit 2
  localparam logic REG_TEMP_MODE   = 1'b0;
  localparam logic REG_BLOCK_INDEX = 1'b1;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_ALIGN = 2'd1,
    OP_PUSH  = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_OVF   = 2'd3
  } err_t;

  typedef struct packed {
    op_t              opcode;
    logic [AMT_W-1:0] amount;
    logic             starts_block;
    logic             starts_data_list;
  } item_t;

  typedef struct packed {
    logic             temp_mode;
    logic [IDX_W-1:0] block_index;
  } cfg_t;

  // core to stack
  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic [OFF_W-1:0] data;
  } stk_cmd_t;

  // stack to core, already reflecting a clear in the same cycle
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [OFF_W-1:0] top;
  } stk_sts_t;

  typedef struct packed {
    logic [LOC_W-1:0] loc;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] peak;
    logic             temp;
    err_t             err;
  } res_t;

endpackage

@@ src/blo_cfg.sv @@
// apb-style register file: temp_mode and block_index
// depends on blo_pkg
`timescale 1ns / 1ps

module blo_cfg
  import blo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic             temp_mode_r;
  logic [IDX_W-1:0] block_index_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_mode_r   <= 1'b0;
      block_index_r <= '0;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_TEMP_MODE) begin
        temp_mode_r <= cfg_pwdata[0];
      end else begin
        block_index_r <= cfg_pwdata[IDX_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TEMP_MODE) begin
      cfg_prdata[0] = temp_mode_r;
    end else begin
      cfg_prdata[IDX_W-1:0] = block_index_r;
    end
  end

  assign cfg.temp_mode   = temp_mode_r;
  assign cfg.block_index = block_index_r;

  `include "assert_macros.svh"

  `BLO_ASSERT(a_temp_wr, wr_en && (cfg_paddr[2] == REG_TEMP_MODE) |=> temp_mode_r == $past(cfg_pwdata[0]), "temp_mode write lost")
  `BLO_ASSERT(a_idx_hold, !wr_en |=> block_index_r == $past(block_index_r), "block_index changed without a write")
  `BLO_ASSERT_NR(a_rst_cfg, !rst_n |=> !temp_mode_r && (block_index_r == '0), "config not cleared by reset")

endmodule

@@ src/blo_stack.sv @@
// offset save stack: top entry cached in a register, the rest in a memory
// with a registered read that prefetches the entry under the top
// depends on blo_pkg
`timescale 1ns / 1ps

module blo_stack
  import blo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stk_cmd_t cmd,
  output stk_sts_t sts
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [OFF_W-1:0] mem [STACK_DEPTH];
  logic [OFF_W-1:0] top_r;
  logic [OFF_W-1:0] under_r;
  logic [DW-1:0]    depth_r;
  logic [DW-1:0]    depth_nxt;
  logic [DW-1:0]    depth_cur;
  logic [DW-1:0]    wr_pos;
  logic [DW-1:0]    rd_pos;
  logic [AW-1:0]    wr_idx;
  logic [AW-1:0]    rd_idx;

  // depth as seen after a block or data list restart
  assign depth_cur = cmd.clear ? '0 : depth_r;
  assign sts.empty = (depth_cur == '0);
  assign sts.full  = (depth_cur == DW'(STACK_DEPTH));
  assign sts.top   = top_r;

  // old top goes one below the new top; pop refills from two below
  assign wr_pos = depth_cur - DW'(1);
  assign rd_pos = depth_cur - DW'(3);
  assign wr_idx = wr_pos[AW-1:0];
  assign rd_idx = rd_pos[AW-1:0];

  always_comb begin
    depth_nxt = depth_cur;
    if (cmd.push) begin
      depth_nxt = depth_cur + DW'(1);
    end else if (cmd.pop) begin
      depth_nxt = depth_cur - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // entries and cached top, no reset
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (!sts.empty) begin
        mem[wr_idx] <= top_r;
      end
      top_r   <= cmd.data;
      under_r <= top_r;
    end else if (cmd.pop) begin
      top_r   <= under_r;
      under_r <= mem[rd_idx];
    end
  end

  `include "assert_macros.svh"

  `BLO_ASSERT(a_depth_max, depth_r <= DW'(STACK_DEPTH), "stack depth beyond capacity")
  `BLO_ASSERT(a_push_top, cmd.push |=> top_r == $past(cmd.data), "pushed offset not on top")
  `BLO_ASSERT(a_cmd_legal, (!cmd.push || !sts.full) && (!cmd.pop || !sts.empty), "push on full or pop on empty")

endmodule

@@ src/blo_core.sv @@
// offset and peak state with the per-chunk update: add or align round,
// saturation, data list restart and push/pop through the stack
// depends on blo_pkg and drives blo_stack
`timescale 1ns / 1ps

module blo_core
  import blo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  item_t    item,
  input  cfg_t     cfg,
  input  stk_sts_t sts,
  output stk_cmd_t cmd,
  output res_t     res
);

  logic [OFF_W-1:0] offset_r;
  logic [OFF_W-1:0] offset_nxt;
  logic [OFF_W-1:0] peak_r;
  logic [OFF_W-1:0] peak_nxt;
  logic [OFF_W-1:0] off0;
  logic [OFF_W-1:0] pk0;
  logic [OFF_W-1:0] pmax;
  logic [OFF_W-1:0] off1;
  logic [AMT_W-1:0] amt_m1;
  logic [AMT_W-1:0] addend;
  logic [OFF_W:0]   sum;
  logic [OFF_W:0]   mask;
  logic [OFF_W:0]   rounded;
  logic             dl;
  logic             align_on;
  logic             push_req;
  logic             pop_req;
  logic             pop_ok;
  err_t             err;

  // restart handling: block start then data list start
  assign off0 = item.starts_block ? '0 : offset_r;
  assign pk0  = item.starts_block ? '0 : peak_r;
  assign pmax = (off0 > pk0) ? off0 : pk0;
  assign dl   = item.starts_data_list && cfg.temp_mode;
  assign off1 = dl ? '0 : off0;

  // one adder for both data and align
  assign amt_m1   = item.amount - AMT_W'(1);
  assign align_on = (item.opcode == OP_ALIGN) && (item.amount > AMT_W'(1));
  assign addend   = (item.opcode == OP_DATA) ? item.amount : amt_m1;
  assign sum      = {1'b0, off1} + {{(OFF_W + 1 - AMT_W){1'b0}}, addend};
  assign mask     = {{(OFF_W + 1 - AMT_W){1'b1}}, ~amt_m1};
  assign rounded  = (item.opcode == OP_DATA) ? sum : (sum & mask);

  assign push_req = (item.opcode == OP_PUSH) && cfg.temp_mode;
  assign pop_req  = (item.opcode == OP_POP) && cfg.temp_mode;
  assign pop_ok   = pop_req && !sts.empty;

  // stack command, only for an accepted chunk
  assign cmd.clear = fire && (item.starts_block || dl);
  assign cmd.push  = fire && push_req && !sts.full;
  assign cmd.pop   = fire && pop_ok;
  assign cmd.data  = off1;

  // next offset and error
  always_comb begin
    offset_nxt = off1;
    err        = ERR_OK;
    case (item.opcode)
      OP_DATA: begin
        if (rounded[OFF_W]) begin
          offset_nxt = OFF_MAX;
          err        = ERR_OVF;
        end else begin
          offset_nxt = rounded[OFF_W-1:0];
        end
      end
      OP_ALIGN: begin
        if (align_on) begin
          if (rounded[OFF_W]) begin
            offset_nxt = OFF_MAX;
            err        = ERR_OVF;
          end else begin
            offset_nxt = rounded[OFF_W-1:0];
          end
        end
      end
      OP_PUSH: begin
        if (push_req && sts.full) begin
          err = ERR_FULL;
        end
      end
      OP_POP: begin
        if (pop_ok) begin
          offset_nxt = sts.top;
        end else if (pop_req) begin
          err = ERR_EMPTY;
        end
      end
      default: begin
        offset_nxt = off1;
      end
    endcase
  end

  // a pop after a data list restart never succeeds, so both take pmax
  assign peak_nxt = (dl || pop_ok) ? pmax : pk0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      peak_r   <= '0;
    end else if (fire) begin
      offset_r <= offset_nxt;
      peak_r   <= peak_nxt;
    end
  end

  assign res.loc    = {cfg.block_index, off1} + LOC_W'(1);
  assign res.offset = offset_nxt;
  assign res.peak   = peak_nxt;
  assign res.temp   = cfg.temp_mode;
  assign res.err    = err;

  `include "assert_macros.svh"

  `BLO_ASSERT(a_ovf_sat, fire && (res.err == ERR_OVF) |=> offset_r == OFF_MAX, "overflow without saturation")
  `BLO_ASSERT(a_normal_peak, fire && !cfg.temp_mode && !item.starts_block |=> peak_r == $past(peak_r), "peak moved in normal mode")
  `BLO_ASSERT(a_idle_hold, !fire |=> (offset_r == $past(offset_r)) && (peak_r == $past(peak_r)), "state changed without a chunk")

endmodule

@@ src/block_layout_offset_calculator.sv @@
// Block layout offset calculator: one chunk word in, one result word out.
// A chunk is accepted in every cycle while the pipeline can move; its result
// passes the input register, the update stage register and the output register
// before it is valid on the output, and can be taken at the next edge.
// The offset add/align round and the stack access are done while the chunk
// is in the update stage, so the rate is one word per cycle while the output
// is not stalled. A pop takes the cached top of stack and refills it from a
// memory with a registered read. The save stack holds STACK_DEPTH offsets.
// Depends on blo_pkg, blo_cfg, blo_stack and blo_core.
`timescale 1ns / 1ps

module block_layout_offset_calculator
  import blo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // amount[31:0]
  input  logic [AMT_W-1:0]  in_tdata,
  // opcode[1:0], starts_block[2], starts_data_list[3]
  input  logic [IN_UW-1:0]  in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // ref_location[63:0], block_size[123:64], error_code[125:124], zero[127:126]
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t     cfg;
  stk_cmd_t cmd;
  stk_sts_t sts;
  res_t     res;

  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             s2_valid_r;
  res_t             s2_res_r;
  logic             out_valid_r;
  logic [LOC_W-1:0] out_loc_r;
  logic [OFF_W-1:0] out_size_r;
  logic [OFF_W-1:0] out_size_nxt;
  err_t             out_err_r;
  logic             s3_ready;
  logic             s2_ready;
  logic             fire;

  blo_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  blo_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  blo_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .sts   (sts),
    .cmd   (cmd),
    .res   (res)
  );

  // pipeline flow control
  assign s3_ready  = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign fire      = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.opcode           <= op_t'(in_tuser[1:0]);
      s1_item_r.amount           <= in_tdata;
      s1_item_r.starts_block     <= in_tuser[2];
      s1_item_r.starts_data_list <= in_tuser[3];
    end
  end

  // update stage register
  always_ff @(posedge clk) begin
    if (fire) begin
      s2_res_r <= res;
    end
  end

  // block size: the peak wins in temporary mode when larger
  assign out_size_nxt = (s2_res_r.temp && (s2_res_r.peak > s2_res_r.offset)) ?
                        s2_res_r.peak : s2_res_r.offset;

  // output register
  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      out_loc_r  <= s2_res_r.loc;
      out_size_r <= out_size_nxt;
      out_err_r  <= s2_res_r.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_err_r, out_size_r, out_loc_r};

  `include "assert_macros.svh"

  `BLO_ASSERT(a_fire_moves, fire |=> s2_valid_r, "accepted chunk lost in update stage")
  `BLO_ASSERT(a_s2_hold, s2_valid_r && !s3_ready |=> s2_valid_r && $stable(s2_res_r), "stalled update result dropped")
  `BLO_ASSERT_NR(a_rst_empty, !rst_n |=> !out_tvalid && !s1_valid_r && !s2_valid_r, "pipeline not empty after reset")

endmodule
